// ===== design/dgmr_pkg.sv =====
// shared types, constants and font tables for the digit glyph matrix renderer
package dgmr_pkg;

  localparam int unsigned VAL_W   = 7;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned INT_W   = 4;
  localparam int unsigned REG_W   = 4;
  localparam int unsigned ROWS    = 8;
  localparam int unsigned ROW_W   = $clog2(ROWS);
  localparam int unsigned CFG_N   = 2;
  localparam int unsigned CFG_IW  = $clog2(CFG_N);
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  localparam logic [REG_W-1:0] REG_ROW_BASE  = 4'h1;
  localparam logic [REG_W-1:0] REG_INTENSITY = 4'hA;

  localparam logic [CFG_IW-1:0] CFG_GAME_INTENSITY  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_CLOCK_INTENSITY = 1'd1;

  localparam logic [INT_W-1:0] GAME_INTENSITY_RST  = 4'd5;
  localparam logic [INT_W-1:0] CLOCK_INTENSITY_RST = 4'd1;

  // 3x5 digits, top row in the high bits
  localparam logic [14:0] SMALL_FONT [0:9] = '{
    {3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
    {3'd2, 3'd6, 3'd2, 3'd2, 3'd7},
    {3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
    {3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
    {3'd5, 3'd5, 3'd7, 3'd1, 3'd1},
    {3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    {3'd7, 3'd4, 3'd7, 3'd5, 3'd7},
    {3'd7, 3'd1, 3'd2, 3'd2, 3'd2},
    {3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
    {3'd7, 3'd5, 3'd7, 3'd1, 3'd7}
  };

  // 5x7 digits, top row in the high bits
  localparam logic [34:0] BIG_FONT [0:9] = '{
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
    {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
  };

  typedef logic [ROWS-1:0][7:0] img_t;

  typedef struct packed {
    logic clock_mode;
    img_t home_img;
    img_t away_img;
  } frame_job_t;

endpackage

// ===== design/dgmr_front.sv =====
// front end: accepts updates, splits digits and renders both rotated images
module dgmr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       clock_mode,
  input  logic                       away_blank,
  input  logic [dgmr_pkg::VAL_W-1:0] away_value,
  input  logic                       home_blank,
  input  logic [dgmr_pkg::VAL_W-1:0] home_value,
  output logic                       job_valid,
  output dgmr_pkg::frame_job_t       job,
  input  logic                       job_full
);
  import dgmr_pkg::*;

  localparam logic [VAL_W-1:0] VAL_MAX = 7'd99;

  typedef struct packed {
    logic             blank;
    logic             big;
    logic [DIG_W-1:0] tens;
    logic [DIG_W-1:0] ones;
  } glyph_sel_t;

  function automatic glyph_sel_t classify(input logic blank, input logic two_digit,
                                          input logic [VAL_W-1:0] v);
    glyph_sel_t g;
    logic [VAL_W-1:0] vc;
    logic [14:0] prod;
    begin
      vc = (v > VAL_MAX) ? VAL_MAX : v;
      // divide by ten via reciprocal 205/2048, exact for every 7-bit input
      prod = 15'(vc) * 15'd205;
      g.tens = DIG_W'(prod >> 11);
      g.ones = DIG_W'(vc - VAL_W'(g.tens) * 7'd10);
      g.blank = blank;
      g.big = (vc < 7'd10) && !two_digit;
      return g;
    end
  endfunction

  function automatic img_t draw(input glyph_sel_t g);
    img_t img;
    logic [14:0] st;
    logic [14:0] so;
    logic [34:0] bg;
    begin
      img = '0;
      st = SMALL_FONT[g.tens];
      so = SMALL_FONT[g.ones];
      bg = BIG_FONT[g.ones];
      if (!g.blank) begin
        if (g.big) begin
          for (int r = 0; r < 7; r++) begin
            img[r] = {2'b00, bg[34-5*r -: 5], 1'b0};
          end
        end else begin
          for (int r = 0; r < 5; r++) begin
            img[r+1] = {1'b0, st[14-3*r -: 3], 1'b0, so[14-3*r -: 3]};
          end
        end
      end
      return img;
    end
  endfunction

  logic [12:0]      hour_prod;
  logic [DIG_W-1:0] hour_q;
  logic [VAL_W-1:0] hour_r;
  logic [VAL_W-1:0] home_eff;
  glyph_sel_t       away_sel;
  glyph_sel_t       home_sel;
  logic             accept;
  logic             advance;

  logic             s1_valid;
  logic             s1_mode;
  glyph_sel_t       s1_away;
  glyph_sel_t       s1_home;

  img_t away_raw;
  img_t home_raw;

  // hour mod 12 via reciprocal 43/512, exact for 7-bit inputs
  always_comb begin
    hour_prod = 13'(home_value) * 13'd43;
    hour_q    = DIG_W'(hour_prod >> 9);
    hour_r    = home_value - VAL_W'(hour_q) * 7'd12;
    if (clock_mode) begin
      home_eff = (hour_r == '0) ? 7'd12 : hour_r;
    end else begin
      home_eff = home_value;
    end
    away_sel = classify(away_blank, clock_mode, away_value);
    home_sel = classify(home_blank, clock_mode, home_eff);
  end

  assign advance = s1_valid && !job_full;
  assign full    = s1_valid && job_full;
  assign accept  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= clock_mode;
      s1_away <= away_sel;
      s1_home <= home_sel;
    end
  end

  // home turned half a turn, away turned a quarter counter-clockwise
  always_comb begin
    away_raw = draw(s1_away);
    home_raw = draw(s1_home);
    job.clock_mode = s1_mode;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < 8; c++) begin
        job.home_img[r][7-c] = home_raw[ROWS-1-r][c];
        job.away_img[r][7-c] = away_raw[c][r];
      end
    end
  end

  assign job_valid = s1_valid;

endmodule

// ===== design/dgmr_queue.sv =====
// short queue of rendered jobs between front end and frame sequencer
module dgmr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  input  dgmr_pkg::frame_job_t wr_job,
  output logic                 wr_full,
  output logic                 rd_valid,
  output dgmr_pkg::frame_job_t rd_job,
  input  logic                 rd_take
);
  import dgmr_pkg::*;

  frame_job_t          slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_wr;
  logic                do_rd;

  assign wr_full  = (count == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && !wr_full;
  assign do_rd    = rd_take && rd_valid;
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== design/dgmr_back.sv =====
// frame sequencer: intensity frame when needed, then eight row frames
module dgmr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dgmr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [dgmr_pkg::INT_W-1:0] cfg_data,
  input  logic                       job_valid,
  input  dgmr_pkg::frame_job_t       job,
  output logic                       job_take,
  output logic                       empty,
  input  logic                       pop,
  output logic [dgmr_pkg::REG_W-1:0] home_register,
  output logic [7:0]                 home_data,
  output logic [dgmr_pkg::REG_W-1:0] away_register,
  output logic [7:0]                 away_data,
  output logic                       last_frame
);
  import dgmr_pkg::*;

  logic [INT_W-1:0] game_intensity;
  logic [INT_W-1:0] clock_intensity;
  logic [INT_W-1:0] current_intensity;

  logic             busy;
  logic             int_pending;
  logic [ROW_W-1:0] row;
  logic [INT_W-1:0] want;
  img_t             home_img;
  img_t             away_img;
  logic             out_valid;

  logic             slot_free;
  logic             emit;
  logic             emit_last;
  logic [INT_W-1:0] want_next;

  assign slot_free = !out_valid || pop;
  assign emit      = busy && slot_free;
  assign emit_last = emit && !int_pending && (row == ROW_W'(ROWS-1));
  assign job_take  = job_valid && (!busy || emit_last);
  assign want_next = job.clock_mode ? clock_intensity : game_intensity;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      game_intensity  <= GAME_INTENSITY_RST;
      clock_intensity <= CLOCK_INTENSITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAME_INTENSITY:  game_intensity  <= cfg_data;
        CFG_CLOCK_INTENSITY: clock_intensity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      int_pending       <= 1'b0;
      row               <= '0;
      out_valid         <= 1'b0;
      current_intensity <= GAME_INTENSITY_RST;
    end else begin
      if (job_take) begin
        busy        <= 1'b1;
        row         <= '0;
        int_pending <= (want_next != current_intensity);
      end else if (emit) begin
        if (int_pending) begin
          int_pending <= 1'b0;
        end else begin
          row <= row + 1'b1;
          if (emit_last) begin
            busy <= 1'b0;
          end
        end
      end
      if (emit && int_pending) begin
        current_intensity <= want;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      want     <= want_next;
      home_img <= job.home_img;
      away_img <= job.away_img;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (int_pending) begin
        home_register <= REG_INTENSITY;
        away_register <= REG_INTENSITY;
        home_data     <= 8'(want);
        away_data     <= 8'(want);
        last_frame    <= 1'b0;
      end else begin
        home_register <= REG_ROW_BASE + REG_W'(row);
        away_register <= REG_ROW_BASE + REG_W'(row);
        home_data     <= home_img[row];
        away_data     <= away_img[row];
        last_frame    <= (row == ROW_W'(ROWS-1));
      end
    end
  end

endmodule

// ===== design/digit_glyph_matrix_renderer_core.sv =====
// top level of the digit glyph matrix renderer
//
// input channel: push/full; one transfer carries an update (mode, blank flags
// and values for the away and home matrices).
// output channel: empty/pop; each transfer is one frame for both drivers
// (register address and data per driver, last_frame on the eighth row).
// config: cfg_we/cfg_index/cfg_data write game (0) or clock (1) intensity.
// an update yields an intensity frame when the mode's intensity differs from
// the one last sent, then eight row frames, so 8 or 9 frames per update.
// on its way, an update passes the front register, the job queue, the sequencer's
// job register and the output register before its first frame is visible.
// throughput: one frame per cycle while the receiver keeps popping, set by the
// frame sequencer; the front end takes the next update while one is emitted.
// reset: queue and output empty, intensities back to 5 (game) and 1 (clock),
// last sent intensity 5.
// a stalled receiver holds the current frame; the sequencer, then the queue,
// then the front end fill up before full rises.
module digit_glyph_matrix_renderer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       clock_mode,
  input  logic                       away_blank,
  input  logic [dgmr_pkg::VAL_W-1:0] away_value,
  input  logic                       home_blank,
  input  logic [dgmr_pkg::VAL_W-1:0] home_value,
  output logic                       empty,
  input  logic                       pop,
  output logic [dgmr_pkg::REG_W-1:0] home_register,
  output logic [7:0]                 home_data,
  output logic [dgmr_pkg::REG_W-1:0] away_register,
  output logic [7:0]                 away_data,
  output logic                       last_frame,
  input  logic                       cfg_we,
  input  logic [dgmr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [dgmr_pkg::INT_W-1:0] cfg_data
);
  import dgmr_pkg::*;

  logic       f_valid;
  frame_job_t f_job;
  logic       q_full;
  logic       q_valid;
  frame_job_t q_job;
  logic       q_take;

  dgmr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .clock_mode (clock_mode),
    .away_blank (away_blank),
    .away_value (away_value),
    .home_blank (home_blank),
    .home_value (home_value),
    .job_valid  (f_valid),
    .job        (f_job),
    .job_full   (q_full)
  );

  dgmr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_job   (f_job),
    .wr_full  (q_full),
    .rd_valid (q_valid),
    .rd_job   (q_job),
    .rd_take  (q_take)
  );

  dgmr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .job_valid     (q_valid),
    .job           (q_job),
    .job_take      (q_take),
    .empty         (empty),
    .pop           (pop),
    .home_register (home_register),
    .home_data     (home_data),
    .away_register (away_register),
    .away_data     (away_data),
    .last_frame    (last_frame)
  );

endmodule

// ===== design/dgmr_checker.sv =====
// port-level assertions for the renderer, bound to the top level
module dgmr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       empty,
  input logic                       pop,
  input logic                       full,
  input logic [dgmr_pkg::REG_W-1:0] home_register,
  input logic [7:0]                 home_data,
  input logic [dgmr_pkg::REG_W-1:0] away_register,
  input logic [7:0]                 away_data,
  input logic                       last_frame
);
  import dgmr_pkg::*;

  // nothing waits right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("output or full set after reset");

  // a frame not taken holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(home_register) && $stable(home_data)
      && $stable(away_register) && $stable(away_data) && $stable(last_frame)))
    else $error("waiting frame changed");

  // both drivers always get the same register
  a_same_reg: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (home_register == away_register))
    else $error("driver registers differ");

  // intensity frames carry one code to both drivers and never end an update
  a_intensity: assert property (@(posedge clk) disable iff (rst)
    (!empty && home_register == REG_INTENSITY) |->
      (home_data == away_data && !last_frame && home_data[7:INT_W] == '0))
    else $error("bad intensity frame");

  // the last frame of an update is the eighth row
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_frame) |-> (home_register == REG_ROW_BASE + REG_W'(ROWS-1)))
    else $error("last frame is not the final row");

endmodule

bind digit_glyph_matrix_renderer_core dgmr_checker u_dgmr_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .full          (full),
  .home_register (home_register),
  .home_data     (home_data),
  .away_register (away_register),
  .away_data     (away_data),
  .last_frame    (last_frame)
);
